// File: sv/rbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and constants of the ray box nearest pick block.
// ----------------------------------------------------------------------------
package rbp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DirW   = 18;
  localparam int unsigned DistW  = 31;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned NumW   = 48;  // slab numerator width, |num| < 2^47
  localparam int unsigned QuotW  = 64;  // numerator magnitude shifted by 16

  localparam logic [DistW-1:0] DistNone = {DistW{1'b1}};
  localparam logic [DistW-1:0] PlaneHalfY = 31'd66;

  typedef enum logic [1:0] {
    SHAPE_BOX     = 2'd0,
    SHAPE_CAPSULE = 2'd1,
    SHAPE_PLANE   = 2'd2,
    SHAPE_RSVD    = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic                     present;
    logic [1:0]               shape;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic signed [CoordW-1:0] scale_x;
    logic signed [CoordW-1:0] scale_y;
    logic signed [CoordW-1:0] scale_z;
    logic [30:0]              capsule_radius;
    logic [30:0]              capsule_height;
    logic                     last;
  } collider_t;

  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  best_index;
    logic [DistW-1:0] best_distance;
  } pick_t;

endpackage

// File: sv/rbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface rbp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/rbp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_div
// Radix-2 restoring divider for slab quotients, one quotient bit a cycle,
// with sign fixup and saturation to signed 32-bit.
// ----------------------------------------------------------------------------
module rbp_div
  import rbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NumW-1:0]  num,
  input  logic signed [DirW-1:0]  den,
  output logic                    done,
  output logic signed [32:0]      quot
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [QuotW-1:0]  dividend;
  logic [DirW-1:0]   divisor;
  logic [DirW:0]     rem;
  logic [CntW-1:0]   count;
  logic              neg;
  logic              busy;

  logic [DirW:0]     rem_shift;
  logic [DirW:0]     rem_sub;
  logic [NumW-1:0]   num_mag;
  logic [DirW-1:0]   den_mag;

  assign num_mag   = num[NumW-1] ? (~num + 1'b1) : num;
  assign den_mag   = den[DirW-1] ? (~den + 1'b1) : den;
  assign rem_shift = {rem[DirW-1:0], dividend[QuotW-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= CntW'(QuotW);
        dividend <= {num_mag, 16'd0};
        divisor  <= den_mag;
        rem      <= '0;
        neg      <= num[NumW-1] ^ den[DirW-1];
      end else if (busy) begin
        if (rem_sub[DirW]) begin
          rem      <= rem_shift;
          dividend <= {dividend[QuotW-2:0], 1'b0};
        end else begin
          rem      <= rem_sub;
          dividend <= {dividend[QuotW-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate and apply sign; dividend now holds the quotient magnitude
  always_comb begin
    if (!neg) begin
      quot = (dividend > QuotW'(32'h7FFF_FFFF)) ? 33'sh0_7FFF_FFFF
                                                 : $signed({1'b0, dividend[31:0]});
    end else begin
      quot = (dividend > QuotW'(32'h8000_0000)) ? -33'sh0_8000_0000
                                                 : -$signed({1'b0, dividend[31:0]});
    end
  end

  cnt_range_a: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QuotW)) else $error("divider count out of range");
  done_after_busy_a: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  start_idle_a: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");

endmodule

// File: sv/rbp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_seq
// Per-collider sequencer: half extents, three slab axes through the shared
// divider, and running nearest-hit tracking.
// ----------------------------------------------------------------------------
module rbp_seq
  import rbp_pkg::*;
#(
  parameter int unsigned MaxColliders = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [CoordW-1:0] origin [3],
  input  logic signed [DirW-1:0]   dir [3],
  input  logic                     in_valid,
  output logic                     in_ready,
  input  collider_t                in_item,
  output logic                     res_valid,
  input  logic                     res_ready,
  output pick_t                    res_item
);

  localparam int unsigned CntW = $clog2(MaxColliders);
  localparam int unsigned ExtW = NumW - 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EXT   = 8'b0000_0010,
    ST_AXIS  = 8'b0000_0100,
    ST_DLO   = 8'b0000_1000,
    ST_DHI   = 8'b0001_0000,
    ST_SLAB  = 8'b0010_0000,
    ST_DONE  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t              state;
  collider_t           item;
  logic [1:0]          axis;
  logic [ExtW-1:0]     ext [3];
  logic signed [32:0]  q_lo;
  logic signed [32:0]  enter;
  logic signed [32:0]  exit_d;
  logic                hit;
  logic [DistW-1:0]    nearest_distance;
  logic [CntW-1:0]     item_counter;
  logic [CntW-1:0]     nearest_index;
  logic                any_hit;

  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic signed [32:0]  quot;
  logic signed [NumW-1:0] num;

  // magnitudes of scale and capsule products
  logic [31:0] as [3];
  logic [31:0] as_max;
  logic [62:0] cap_r;
  logic [62:0] cap_h;
  always_comb begin
    as[0]  = item.scale_x[31] ? 32'(-item.scale_x) : 32'(item.scale_x);
    as[1]  = item.scale_y[31] ? 32'(-item.scale_y) : 32'(item.scale_y);
    as[2]  = item.scale_z[31] ? 32'(-item.scale_z) : 32'(item.scale_z);
    as_max = (as[0] > as[2]) ? as[0] : as[2];
    cap_r  = 63'(item.capsule_radius) * 63'(as_max);
    cap_h  = 63'(item.capsule_height) * 63'(as[1]);
  end

  // half extents per shape, box is |s| * 50
  logic [ExtW-1:0] ext_n [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext_n[i] = (ExtW'(as[i]) << 5) + (ExtW'(as[i]) << 4) + (ExtW'(as[i]) << 1);
    end
    case (shape_t'(item.shape))
      SHAPE_CAPSULE: begin
        ext_n[0] = ExtW'(cap_r >> 16);
        ext_n[1] = ExtW'(cap_h >> 17);
        ext_n[2] = ExtW'(cap_r >> 16);
      end
      SHAPE_PLANE: ext_n[1] = ExtW'(PlaneHalfY);
      default: ;
    endcase
  end

  // current axis operands
  logic signed [CoordW-1:0] c_ax;
  logic signed [CoordW-1:0] o_ax;
  logic signed [DirW-1:0]   d_ax;
  logic signed [NumW-1:0]   lo_ax;
  logic signed [NumW-1:0]   hi_ax;
  always_comb begin
    case (axis)
      2'd0:    c_ax = item.center_x;
      2'd1:    c_ax = item.center_y;
      default: c_ax = item.center_z;
    endcase
    o_ax  = origin[axis];
    d_ax  = dir[axis];
    lo_ax = NumW'(c_ax) - $signed({1'b0, ext[axis]});
    hi_ax = NumW'(c_ax) + $signed({1'b0, ext[axis]});
  end

  assign num       = (state == ST_DLO) ? (lo_ax - NumW'(o_ax)) : (hi_ax - NumW'(o_ax));
  assign div_start = ((state == ST_DLO) || (state == ST_DHI)) && !div_busy;

  rbp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (d_ax),
    .done  (div_done),
    .quot  (quot)
  );

  logic signed [32:0] q_min;
  logic signed [32:0] q_max;
  logic signed [32:0] enter_n;
  logic signed [32:0] exit_n;
  assign q_min   = (q_lo > quot) ? quot : q_lo;
  assign q_max   = (q_lo > quot) ? q_lo : quot;
  assign enter_n = (q_min > enter) ? q_min : enter;
  assign exit_n  = (q_max < exit_d) ? q_max : exit_d;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign res_item.found         = any_hit;
  assign res_item.best_index    = any_hit ? IdxW'(nearest_index) : '0;
  assign res_item.best_distance = any_hit ? nearest_distance : DistNone;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      div_busy         <= 1'b0;
      nearest_distance <= DistNone;
      nearest_index    <= '0;
      any_hit          <= 1'b0;
      item_counter     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= in_item.present ? ST_EXT : ST_DONE;
          end
        end
        ST_EXT: begin
          ext[0] <= ext_n[0];
          ext[1] <= ext_n[1];
          ext[2] <= ext_n[2];
          axis   <= 2'd0;
          enter  <= '0;
          exit_d <= 33'sh0_7FFF_FFFF;
          hit    <= 1'b1;
          state  <= ST_AXIS;
        end
        ST_AXIS: begin
          if (!hit || axis == 2'd3) begin
            state <= ST_SLAB;
          end else if (d_ax == '0) begin
            hit  <= (NumW'(o_ax) >= lo_ax) && (NumW'(o_ax) <= hi_ax);
            axis <= axis + 2'd1;
          end else begin
            state <= ST_DLO;
          end
        end
        ST_DLO: begin
          if (div_start) div_busy <= 1'b1;
          if (div_done) begin
            q_lo     <= quot;
            div_busy <= 1'b0;
            state    <= ST_DHI;
          end
        end
        ST_DHI: begin
          if (div_start) div_busy <= 1'b1;
          if (div_done) begin
            div_busy <= 1'b0;
            enter    <= enter_n;
            exit_d   <= exit_n;
            if (enter_n > exit_n) hit <= 1'b0;
            axis  <= axis + 2'd1;
            state <= ST_AXIS;
          end
        end
        ST_SLAB: begin
          if (hit && !enter[32] && enter < $signed({2'b00, nearest_distance})) begin
            nearest_distance <= enter[DistW-1:0];
            nearest_index    <= item_counter;
            any_hit          <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          item_counter <= (32'(item_counter) + 32'd1 >= 32'(MaxColliders))
                          ? '0 : item_counter + 1'b1;
          state <= item.last ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (res_ready) begin
            nearest_distance <= DistNone;
            nearest_index    <= '0;
            any_hit          <= 1'b0;
            item_counter     <= '0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  out_last_a: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(item.last)) else $error("result without last item");
  hit_dist_a: assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> nearest_distance == DistNone) else $error("distance without hit");
  ready_out_a: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && res_valid)) else $error("accepting while result pending");

endmodule

// File: sv/ray_box_nearest_pick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_nearest_pick_core
// Streams colliders against a configured ray and returns the nearest hit.
// ----------------------------------------------------------------------------
// One collider item is taken at a time. From one accepted item to the next, a
// present collider passes the accept state, a setup state, then per axis with
// nonzero direction a check state plus two passes through the single radix-2
// divider (start, 64 quotient bits, done), then the closing axis check, slab
// and done states. An axis with zero direction takes only its check state and
// a miss skips the remaining axes; an absent collider goes from accept straight
// to done. The divider sets the rate. The result item appears after the item
// marked last and must be taken before the next collider is accepted.
module ray_box_nearest_pick_core
  import rbp_pkg::*;
#(
  parameter int unsigned MAX_COLLIDERS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rbp_if.sink         in_ch,
  rbp_if.source       out_ch
);

  logic signed [CoordW-1:0] origin [3];
  logic signed [DirW-1:0]   dir [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        dir[i]    <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ORIGIN_X: origin[0] <= cfg_data;
        CFG_ORIGIN_Y: origin[1] <= cfg_data;
        CFG_ORIGIN_Z: origin[2] <= cfg_data;
        CFG_DIR_X:    dir[0]    <= cfg_data[DirW-1:0];
        CFG_DIR_Y:    dir[1]    <= cfg_data[DirW-1:0];
        CFG_DIR_Z:    dir[2]    <= cfg_data[DirW-1:0];
        default: ;
      endcase
    end
  end

  rbp_seq #(
    .MaxColliders (MAX_COLLIDERS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .origin    (origin),
    .dir       (dir),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.data),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_item  (out_ch.data)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams collider items against several configured rays and checks each
// pick result against a bit-accurate slab-test predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import rbp_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  bit failed;

  rbp_if #(.payload_t(collider_t)) in_ch ();
  rbp_if #(.payload_t(pick_t)) out_ch ();

  ray_box_nearest_pick_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state: ray registers and running pick
  logic signed [31:0] org [3];
  logic signed [17:0] dir [3];
  logic [30:0] near_dist;
  logic [9:0] near_idx;
  bit any_hit;
  int unsigned pos_cnt;
  pick_t pick_q[$];
  int unsigned hold_off;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // slab quotient in Q16.16, truncated and saturated
  function automatic longint slab_quot(longint num, longint d);
    longint unsigned q;
    bit neg;
    q = (mag(num) << 16) / mag(d);
    neg = (num < 0) != (d < 0);
    if (!neg) return q > 64'h7FFFFFFF ? 64'h7FFFFFFF : longint'(q);
    if (q > 64'h80000000) return -longint'(64'h80000000);
    return -longint'(q);
  endfunction

  task automatic predict_collider(input collider_t c);
    longint ctr [3];
    longint unsigned asc [3];
    longint unsigned hx [3];
    longint enter, exit_d, lo, hi, nv, fv, t;
    longint unsigned m;
    bit hit;
    pick_t r;
    ctr[0] = c.center_x; ctr[1] = c.center_y; ctr[2] = c.center_z;
    asc[0] = mag(longint'(c.scale_x));
    asc[1] = mag(longint'(c.scale_y));
    asc[2] = mag(longint'(c.scale_z));
    for (int i = 0; i < 3; i++) hx[i] = asc[i] * 50;
    if (c.present) begin
      enter = 0;
      exit_d = 64'h7FFFFFFF;
      hit = 1;
      if (c.shape == SHAPE_CAPSULE) begin
        m = asc[0] > asc[2] ? asc[0] : asc[2];
        hx[0] = (longint'(c.capsule_radius) * m) >> 16;
        hx[2] = hx[0];
        hx[1] = (longint'(c.capsule_height) * asc[1]) >> 17;
      end else if (c.shape == SHAPE_PLANE) begin
        hx[1] = PlaneHalfY;
      end
      for (int i = 0; i < 3 && hit; i++) begin
        lo = ctr[i] - longint'(hx[i]);
        hi = ctr[i] + longint'(hx[i]);
        if (dir[i] == 0) begin
          hit = longint'(org[i]) >= lo && longint'(org[i]) <= hi;
        end else begin
          nv = slab_quot(lo - org[i], dir[i]);
          fv = slab_quot(hi - org[i], dir[i]);
          if (nv > fv) begin
            t = nv; nv = fv; fv = t;
          end
          if (nv > enter) enter = nv;
          if (fv < exit_d) exit_d = fv;
          if (enter > exit_d) hit = 0;
        end
      end
      if (hit && enter >= 0 && enter < longint'(near_dist)) begin
        near_dist = enter[30:0];
        near_idx = pos_cnt[9:0];
        any_hit = 1;
      end
    end
    pos_cnt = (pos_cnt + 1 >= 1024) ? 0 : pos_cnt + 1;
    if (c.last) begin
      r.found = any_hit;
      r.best_index = any_hit ? near_idx : '0;
      r.best_distance = any_hit ? near_dist : DistNone;
      pick_q.push_back(r);
      near_dist = DistNone;
      near_idx = '0;
      any_hit = 0;
      pos_cnt = 0;
    end
  endtask

  // sender with random bursts and gaps
  int burst_left;

  task automatic send_collider(input collider_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_collider(c);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      CFG_ORIGIN_X: org[0] = val;
      CFG_ORIGIN_Y: org[1] = val;
      CFG_ORIGIN_Z: org[2] = val;
      CFG_DIR_X: dir[0] = val[17:0];
      CFG_DIR_Y: dir[1] = val[17:0];
      default: dir[2] = val[17:0];
    endcase
  endtask

  // stop offering items, wait until idle, then let the block settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pick_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, input logic [17:0] dx, dy, dz);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, {{14{dx[17]}}, dx});
    write_reg(CFG_DIR_Y, {{14{dy[17]}}, dy});
    write_reg(CFG_DIR_Z, {{14{dz[17]}}, dz});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(input int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic collider_t rand_collider(input bit lst);
    collider_t c;
    c.present = $urandom_range(0, 9) != 0;
    c.shape = 2'($urandom_range(0, 3));
    c.center_x = rand_coord(32'h000A0000);
    c.center_y = rand_coord(32'h000A0000);
    c.center_z = rand_coord(32'h000A0000);
    c.scale_x = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 32'h20000) - 32'h10000;
    c.scale_y = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 32'h20000) - 32'h10000;
    c.scale_z = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 32'h20000) - 32'h10000;
    c.capsule_radius = 31'($urandom_range(0, 7) == 0 ? $urandom()
                                                     : $urandom_range(0, 32'h40000));
    c.capsule_height = 31'($urandom_range(0, 7) == 0 ? $urandom()
                                                     : $urandom_range(0, 32'h80000));
    c.last = lst;
    return c;
  endfunction

  function automatic logic [17:0] rand_dir();
    case ($urandom_range(0, 6))
      0: return 18'd0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      3: return 18'($urandom_range(1, 3));
      default: return 18'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  // directed: extremes, every shape, zero direction, absent and empty picks
  task automatic test_directed;
    collider_t c;
    set_ray(32'hFFF60000, 0, 0, 18'sd65536, 0, 0);
    c = '0;
    c.present = 1; c.shape = SHAPE_BOX; c.scale_x = 32'h00000800;
    c.scale_y = 32'h00000800; c.scale_z = 32'h00000800;
    send_collider(c);
    c.center_x = 32'h00050000; send_collider(c);
    c.center_x = 0; send_collider(c);                // tie: earlier wins
    c.shape = SHAPE_CAPSULE; c.capsule_radius = 31'h7FFFFFFF;
    c.capsule_height = 31'h7FFFFFFF; c.scale_x = 32'h80000000;
    c.scale_y = 32'h7FFFFFFF; send_collider(c);
    c.shape = SHAPE_PLANE; c.center_y = 32'h00000100; send_collider(c);
    c.shape = SHAPE_RSVD; c.center_x = 32'h7FFFFFFF; send_collider(c);
    c.present = 0; c.last = 1; send_collider(c);
    c.present = 0; c.last = 1; send_collider(c);     // empty pick
    set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 18'd1, -18'sd65536, 18'd0);
    c = '0; c.present = 1; c.shape = SHAPE_BOX;
    c.scale_x = 32'h7FFFFFFF; c.scale_y = 32'h80000000; c.scale_z = 32'h7FFFFFFF;
    c.center_x = 32'h80000000; c.center_y = 32'h7FFFFFFF; c.center_z = 32'h7FFFFFFF;
    send_collider(c);
    c.center_z = 32'h80000000; c.last = 1; send_collider(c);
    set_ray(0, 0, 0, 0, 0, 0);
    c = '0; c.present = 1; c.last = 1; send_collider(c);  // all axes containment
  endtask

  // random picks under several rays, small picks mostly
  task automatic test_random;
    int n, total;
    total = 0;
    while (total < 470) begin
      if ($urandom_range(0, 3) == 0)
        set_ray(rand_coord(32'h00140000), rand_coord(32'h00140000), rand_coord(32'h00140000),
                rand_dir(), rand_dir(), rand_dir());
      n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) send_collider(rand_collider(k == n - 1));
      total += n;
    end
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure;
    set_ray(32'hFFEC0000, 0, 0, 18'sd65536, 0, 0);
    hold_off = 3000;
    for (int k = 0; k < 10; k++) send_collider(rand_collider(k % 2 == 1));
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 15) < 4) ? 1'b0 : 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    pick_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pick_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.data);
        failed = 1;
      end else begin
        exp_r = pick_q.pop_front();
        if (out_ch.data.found !== exp_r.found)
          $display("%0t: found exp %0d got %0d", $time, exp_r.found, out_ch.data.found);
        if (out_ch.data.best_index !== exp_r.best_index)
          $display("%0t: best_index exp %0d got %0d", $time, exp_r.best_index,
                   out_ch.data.best_index);
        if (out_ch.data.best_distance !== exp_r.best_distance)
          $display("%0t: best_distance exp %h got %h", $time, exp_r.best_distance,
                   out_ch.data.best_distance);
        if (out_ch.data !== exp_r) failed = 1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    hold_off = 0; burst_left = 0; failed = 0;
    for (int i = 0; i < 3; i++) begin
      org[i] = '0; dir[i] = '0;
    end
    near_dist = DistNone; near_idx = '0; any_hit = 0; pos_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
